@@ rtl/blss_pkg.sv @@
// blss_pkg: shared types and constants of the byte LIFO stack with search.
// Used by byte_lifo_stack_with_search_core and blss_ram; depends on nothing.
package blss_pkg;

    localparam int DATA_W  = 8;
    localparam int OUT_CNT_W = 7;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_SEARCH = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEARCH,
        S_PEND
    } state_t;

    typedef struct packed {
        logic                 is_empty;
        logic [OUT_CNT_W-1:0] entry_count;
        status_t              status;
        logic [OUT_CNT_W-1:0] match_distance;
        logic [DATA_W-1:0]    data_out;
    } res_t;

endpackage

@@ rtl/blss_ram.sv @@
// blss_ram: single-clock byte store, one write and one read port, registered read.
// Depends on blss_pkg for the data width.
module blss_ram #(
    parameter int DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [blss_pkg::DATA_W-1:0]   wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [blss_pkg::DATA_W-1:0]   rd_data
);

    logic [blss_pkg::DATA_W-1:0] mem [DEPTH];
    logic [blss_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/byte_lifo_stack_with_search_core.sv @@
// byte_lifo_stack_with_search_core: fixed-depth byte LIFO with push, pop, peek,
// search and clear. Depends on blss_pkg and blss_ram.
//
//  channel | dir | handshake        | word
//  s_      | in  | s_tvalid/tready  | s_tdata: operation, value
//  m_      | out | m_tvalid/tready  | m_tdata: data_out, match_distance, status,
//          |     |                  |          entry_count, is_empty
//
// Push, clear, unused codes and refused operations: the result is formed from the accepted word and registered.
// Pop and peek: the result waits for the registered read of the entry store.
// Search: one entry compared per cycle from the top through the store's single read port,
// until a hit or the last entry; search of an empty stack answers straight from the accepted word.
// Reset empties the stack at once; no clearing pass. A result that meets a
// stalled output is parked and holds s_tready low until the output frees.
module byte_lifo_stack_with_search_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [2:0] operation, [10:3] value, [15:11] zero
    input  logic [blss_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] data_out, [14:8] match_distance, [16:15] status,
    // [23:17] entry_count, [24] is_empty, [31:25] zero
    output logic [blss_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int EXT_W = (CNT_W > blss_pkg::OUT_CNT_W) ? CNT_W : blss_pkg::OUT_CNT_W;

    blss_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] dist_reg, dist_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [blss_pkg::DATA_W-1:0] key_reg, key_next;
    blss_pkg::res_t   pend_reg, pend_next;
    blss_pkg::res_t   out_reg, out_next;
    logic             m_tvalid_reg, m_tvalid_next;

    blss_pkg::op_t    op;
    logic [blss_pkg::DATA_W-1:0] in_value;
    logic             accept;
    logic             out_free;
    logic             is_full;
    logic             search_hit;
    logic             search_end;

    logic             fin_valid;
    blss_pkg::res_t   fin_res;
    logic [CNT_W-1:0] fin_count;
    logic [CNT_W-1:0] fin_dist;
    logic [EXT_W-1:0] fin_count_ext;
    logic [EXT_W-1:0] fin_dist_ext;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [blss_pkg::DATA_W-1:0] rd_data;

    assign op       = blss_pkg::op_t'(s_tdata[blss_pkg::OP_W-1:0]);
    assign in_value = s_tdata[blss_pkg::OP_W +: blss_pkg::DATA_W];
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_full  = (count_reg >= CNT_W'(STACK_DEPTH));

    assign search_hit = (rd_data == key_reg);
    assign search_end = (dist_reg == count_reg);

    blss_ram #(
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // handshake and store control
    always_comb begin
        s_tready = (state_reg == blss_pkg::S_IDLE);
        wr_en    = 1'b0;
        wr_addr  = count_reg[AW-1:0];
        rd_en    = 1'b0;
        rd_addr  = ptr_reg - AW'(1);
        unique case (state_reg)
            blss_pkg::S_IDLE: begin
                rd_addr = AW'(count_reg - CNT_W'(1));
                if (accept) begin
                    unique case (op)
                        blss_pkg::OP_PUSH:   wr_en = !is_full;
                        blss_pkg::OP_POP,
                        blss_pkg::OP_PEEK,
                        blss_pkg::OP_SEARCH: rd_en = (count_reg != '0);
                        default: ;
                    endcase
                end
            end
            blss_pkg::S_SEARCH: rd_en = !search_hit && !search_end;
            default: ;
        endcase
    end

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        dist_next  = dist_reg;
        ptr_next   = ptr_reg;
        key_next   = key_reg;
        fin_valid  = 1'b0;
        fin_count  = count_reg;
        fin_dist   = '0;
        fin_res    = '0;
        fin_res.status = blss_pkg::ST_OK;

        unique case (state_reg)
            blss_pkg::S_IDLE: begin
                if (accept) begin
                    fin_valid = 1'b1;
                    key_next  = in_value;
                    unique case (op)
                        blss_pkg::OP_PUSH: begin
                            if (is_full) begin
                                fin_res.status = blss_pkg::ST_OVERFLOW;
                            end else begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        blss_pkg::OP_POP: begin
                            if (count_reg == '0) begin
                                fin_res.status = blss_pkg::ST_UNDERFLOW;
                            end else begin
                                fin_valid  = 1'b0;
                                count_next = count_reg - CNT_W'(1);
                                state_next = blss_pkg::S_READ;
                            end
                        end
                        blss_pkg::OP_PEEK: begin
                            if (count_reg == '0) begin
                                fin_res.status = blss_pkg::ST_UNDERFLOW;
                            end else begin
                                fin_valid  = 1'b0;
                                state_next = blss_pkg::S_READ;
                            end
                        end
                        blss_pkg::OP_SEARCH: begin
                            if (count_reg != '0) begin
                                fin_valid  = 1'b0;
                                dist_next  = CNT_W'(1);
                                ptr_next   = AW'(count_reg - CNT_W'(1));
                                state_next = blss_pkg::S_SEARCH;
                            end
                        end
                        blss_pkg::OP_CLEAR: count_next = '0;
                        default: ;
                    endcase
                    fin_count = count_next;
                end
            end
            blss_pkg::S_READ: begin
                fin_valid        = 1'b1;
                fin_res.data_out = rd_data;
            end
            blss_pkg::S_SEARCH: begin
                if (search_hit) begin
                    fin_valid = 1'b1;
                    fin_dist  = dist_reg;
                end else if (search_end) begin
                    fin_valid = 1'b1;
                end else begin
                    ptr_next  = ptr_reg - AW'(1);
                    dist_next = dist_reg + CNT_W'(1);
                end
            end
            blss_pkg::S_PEND: begin
                if (out_free) begin
                    state_next = blss_pkg::S_IDLE;
                end
            end
            default: state_next = blss_pkg::S_IDLE;
        endcase

        fin_count_ext          = EXT_W'(fin_count);
        fin_dist_ext           = EXT_W'(fin_dist);
        fin_res.entry_count    = fin_count_ext[blss_pkg::OUT_CNT_W-1:0];
        fin_res.match_distance = fin_dist_ext[blss_pkg::OUT_CNT_W-1:0];
        fin_res.is_empty       = (fin_count == '0);

        if (fin_valid) begin
            state_next = out_free ? blss_pkg::S_IDLE : blss_pkg::S_PEND;
        end
    end

    // result register and parking slot
    always_comb begin
        pend_next     = pend_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (state_reg == blss_pkg::S_PEND) begin
            if (out_free) begin
                out_next      = pend_reg;
                m_tvalid_next = 1'b1;
            end
        end else if (fin_valid) begin
            if (out_free) begin
                out_next      = fin_res;
                m_tvalid_next = 1'b1;
            end else begin
                pend_next = fin_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= blss_pkg::S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg <= dist_next;
        ptr_reg  <= ptr_next;
        key_reg  <= key_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = blss_pkg::M_TDATA_W'(out_reg);

endmodule
